// ===== rtl/core/bmpc_pkg.sv =====
// bmpc_pkg: shared constants, codes and helpers for barometer raw compensation
// used by bmpc_div and barometer_raw_compensation; no dependencies
package bmpc_pkg;

  localparam int unsigned DivW = 32;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBusy    = 2'd1;
  localparam logic [1:0] StDivZero = 2'd2;

  localparam logic [1:0] RegA123 = 2'd0;
  localparam logic [1:0] RegA456 = 2'd1;
  localparam logic [1:0] RegB12  = 2'd2;
  localparam logic [1:0] RegMcMd = 2'd3;

  localparam int unsigned BusyBit = 5;
  localparam logic signed [31:0] TempOffs = 32'sd4000;
  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic signed [31:0] PressMid = 32'sd32768;
  localparam logic signed [31:0] Ka = 32'sd3038;
  localparam logic signed [31:0] Kb = -32'sd7357;
  localparam logic signed [31:0] Kc = 32'sd3791;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] v,
                                                   input int unsigned k);
    logic signed [31:0] bias;
    bias = v[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (v + bias) >>> k;
  endfunction

endpackage

// ===== rtl/core/barometer_raw_compensation.sv =====
// barometer_raw_compensation: integer temperature and pressure compensation
// depends on bmpc_pkg and bmpc_div
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata: tctrl, traw, pctrl, praw
//  m_axis    out  tvalid/tready             tdata: temp, pressure; tuser: status
//  cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// one word per cycle while the output word does not wait; 17 arithmetic stages plus two
// 32-stage bit-per-cycle dividers
// the whole pipe moves together; it holds when the output word waits
// reset clears valid bits and coefficients; cfg is always ready
module barometer_raw_compensation
  import bmpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // temp_ctrl_byte, temp_raw, press_ctrl_byte, press_raw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // temp_tenths_c, pressure_pa
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  typedef struct packed {
    logic               busy;
    logic               dz;
    logic               neg;
    logic [1:0]         oss;
    logic [18:0]        up;
    logic signed [31:0] x1;
  } side1_t;

  typedef struct packed {
    logic               busy;
    logic               dz;
    logic               big;
    logic signed [31:0] t;
  } side2_t;

  logic [47:0] c0_q, c1_q;
  logic [31:0] c2_q, c3_q;
  logic adv;

  assign cfg_ready_o = 1'b1;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegA123: c0_q <= cfg_data_i;
        RegA456: c1_q <= cfg_data_i;
        RegB12:  c2_q <= cfg_data_i[31:0];
        RegMcMd: c3_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0] ac4, ac5, ac6;
  assign ac1 = {{16{c0_q[47]}}, c0_q[47:32]};
  assign ac2 = {{16{c0_q[31]}}, c0_q[31:16]};
  assign ac3 = {{16{c0_q[15]}}, c0_q[15:0]};
  assign ac4 = c1_q[47:32];
  assign ac5 = c1_q[31:16];
  assign ac6 = c1_q[15:0];
  assign b1  = {{16{c2_q[31]}}, c2_q[31:16]};
  assign b2  = {{16{c2_q[15]}}, c2_q[15:0]};
  assign mc  = {{16{c3_q[31]}}, c3_q[31:16]};
  assign md  = {{16{c3_q[15]}}, c3_q[15:0]};

  // stage 0: capture
  logic v0_q, busy0_q;
  logic [1:0] oss0_q;
  logic [15:0] ut0_q;
  logic [18:0] up0_q;
  logic [1:0] oss_in;
  logic [23:0] up_sh;
  assign oss_in = s_axis_tdata[31:30];
  assign up_sh  = s_axis_tdata[55:32] >> (4'd8 - {2'b00, oss_in});

  // stage 1
  logic v1_q, busy1_q;
  logic [1:0] oss1_q;
  logic [18:0] up1_q;
  logic signed [31:0] m1_q;
  logic signed [16:0] tdiff;
  logic signed [33:0] m1_full;
  assign tdiff   = $signed({1'b0, ut0_q}) - $signed({1'b0, ac6});
  assign m1_full = tdiff * $signed({1'b0, ac5});

  // stage 2
  logic v2_q;
  side1_t s2_q;
  logic [31:0] na2_q, da2_q;
  logic signed [31:0] x1_2, den2, num2;
  assign x1_2 = sdiv_pow2(m1_q, 15);
  assign den2 = x1_2 + md;
  assign num2 = mc <<< 11;

  // divider 1
  logic dv1;
  logic [31:0] q1;
  side1_t sd1_q [32];

  bmpc_div u_div_t (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q),
    .num_i(na2_q), .den_i(da2_q), .valid_o(dv1), .quo_o(q1)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd1_q[0] <= s2_q;
      for (int i = 1; i < 32; i++) sd1_q[i] <= sd1_q[i-1];
    end
  end

  // stage 3
  logic v3_q, busy3_q, dz3_q;
  logic [1:0] oss3_q;
  logic [18:0] up3_q;
  logic signed [31:0] t3_q, b6_3_q;
  logic signed [31:0] x2_3, b5_3;
  assign x2_3 = sd1_q[31].neg ? -$signed(q1) : $signed(q1);
  assign b5_3 = sd1_q[31].x1 + x2_3;

  // stage 4..11
  logic v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  logic busy4_q, busy5_q, busy6_q, busy7_q, busy8_q, busy9_q, busy10_q, busy11_q;
  logic dz4_q, dz5_q, dz6_q, dz7_q, dz8_q, dz9_q, dz10_q, dz11_q;
  logic [1:0] oss4_q, oss5_q, oss6_q, oss7_q, oss8_q, oss9_q;
  logic [18:0] up4_q, up5_q, up6_q, up7_q, up8_q;
  logic signed [31:0] t4_q, t5_q, t6_q, t7_q, t8_q, t9_q, t10_q, t11_q;
  logic signed [31:0] sqr4_q, m2_4_q, m3_4_q;
  logic signed [31:0] sq5_q, x2a5_q, x1c5_q;
  logic signed [31:0] b2sq6_q, b1sq6_q, x2a6_q, x1c6_q;
  logic signed [31:0] pre7_q, v7v_q;
  logic signed [31:0] b3_8_q;
  logic [31:0] b4p8_q;
  logic [31:0] b4_9_q, diff9_q;
  logic [31:0] b4_10_q, b7_10_q;
  logic [31:0] na11_q, da11_q;
  logic big11_q;

  logic signed [31:0] x1_7, x2b_7, x3b_7;
  assign x1_7  = sdiv_pow2(b2sq6_q, 11);
  assign x2b_7 = sdiv_pow2(b1sq6_q, 16);
  assign x3b_7 = sdiv_pow2(x1c6_q + x2b_7 + 32'sd2, 2);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      busy0_q <= s_axis_tdata[BusyBit] | s_axis_tdata[24+BusyBit];
      oss0_q  <= oss_in;
      ut0_q   <= s_axis_tdata[23:8];
      up0_q   <= up_sh[18:0];

      busy1_q <= busy0_q;
      oss1_q  <= oss0_q;
      up1_q   <= up0_q;
      m1_q    <= m1_full[31:0];

      s2_q.busy <= busy1_q;
      s2_q.dz   <= (den2 == 32'sd0);
      s2_q.neg  <= num2[31] ^ den2[31];
      s2_q.oss  <= oss1_q;
      s2_q.up   <= up1_q;
      s2_q.x1   <= x1_2;
      na2_q     <= num2[31] ? 32'(-num2) : 32'(num2);
      da2_q     <= den2[31] ? 32'(-den2) : 32'(den2);

      busy3_q <= sd1_q[31].busy;
      dz3_q   <= sd1_q[31].dz;
      oss3_q  <= sd1_q[31].oss;
      up3_q   <= sd1_q[31].up;
      t3_q    <= sdiv_pow2(b5_3 + 32'sd8, 4);
      b6_3_q  <= b5_3 - TempOffs;

      busy4_q <= busy3_q; dz4_q <= dz3_q; oss4_q <= oss3_q; up4_q <= up3_q; t4_q <= t3_q;
      sqr4_q  <= b6_3_q * b6_3_q;
      m2_4_q  <= ac2 * b6_3_q;
      m3_4_q  <= ac3 * b6_3_q;

      busy5_q <= busy4_q; dz5_q <= dz4_q; oss5_q <= oss4_q; up5_q <= up4_q; t5_q <= t4_q;
      sq5_q   <= sdiv_pow2(sqr4_q, 12);
      x2a5_q  <= sdiv_pow2(m2_4_q, 11);
      x1c5_q  <= sdiv_pow2(m3_4_q, 13);

      busy6_q <= busy5_q; dz6_q <= dz5_q; oss6_q <= oss5_q; up6_q <= up5_q; t6_q <= t5_q;
      b2sq6_q <= b2 * sq5_q;
      b1sq6_q <= b1 * sq5_q;
      x2a6_q  <= x2a5_q;
      x1c6_q  <= x1c5_q;

      busy7_q <= busy6_q; dz7_q <= dz6_q; oss7_q <= oss6_q; up7_q <= up6_q; t7_q <= t6_q;
      pre7_q  <= (ac1 <<< 2) + x1_7 + x2a6_q;
      v7v_q   <= x3b_7 + PressMid;

      busy8_q <= busy7_q; dz8_q <= dz7_q; oss8_q <= oss7_q; up8_q <= up7_q; t8_q <= t7_q;
      b3_8_q  <= sdiv_pow2((pre7_q <<< oss7_q) + 32'sd2, 2);
      b4p8_q  <= {16'd0, ac4} * v7v_q;

      busy9_q <= busy8_q; dz9_q <= dz8_q; oss9_q <= oss8_q; t9_q <= t8_q;
      b4_9_q  <= b4p8_q >> 15;
      diff9_q <= {13'd0, up8_q} - b3_8_q;

      busy10_q <= busy9_q; dz10_q <= dz9_q; t10_q <= t9_q;
      b4_10_q  <= b4_9_q;
      b7_10_q  <= diff9_q * (PressScale >> oss9_q);

      busy11_q <= busy10_q; t11_q <= t10_q;
      dz11_q   <= dz10_q | (b4_10_q == 32'd0);
      big11_q  <= b7_10_q[31];
      na11_q   <= b7_10_q[31] ? b7_10_q : {b7_10_q[30:0], 1'b0};
      da11_q   <= b4_10_q;
    end
  end

  // divider 2
  logic dv2;
  logic [31:0] q2;
  side2_t sd2_q [32];
  side2_t s11;
  assign s11 = '{busy: busy11_q, dz: dz11_q, big: big11_q, t: t11_q};

  bmpc_div u_div_p (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v11_q),
    .num_i(na11_q), .den_i(da11_q), .valid_o(dv2), .quo_o(q2)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd2_q[0] <= s11;
      for (int i = 1; i < 32; i++) sd2_q[i] <= sd2_q[i-1];
    end
  end

  // stages 12..16
  logic v12_q, v13_q, v14_q, v15_q;
  side2_t s12_q, s13_q, s14_q, s15_q;
  logic signed [31:0] p12_q, p13_q, p14_q, p15_q;
  logic signed [31:0] xx13_q, m7_13_q, m7_14_q, m3_14_q, corr15_q;
  logic signed [31:0] x1_13, sum_15;
  assign x1_13  = sdiv_pow2(p12_q, 8);
  assign sum_15 = sdiv_pow2(m3_14_q, 16) + sdiv_pow2(m7_14_q, 16) + Kc;

  logic [1:0] st_d;
  logic ok15;
  assign ok15 = !s15_q.busy && !s15_q.dz;
  assign st_d = s15_q.busy ? StBusy : (s15_q.dz ? StDivZero : StOk);

  logic v16_q;
  logic [1:0] st16_q;
  logic signed [31:0] t16_q, p16_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s12_q   <= sd2_q[31];
      p12_q   <= sd2_q[31].big ? $signed({q2[30:0], 1'b0}) : $signed(q2);

      s13_q   <= s12_q;
      p13_q   <= p12_q;
      xx13_q  <= x1_13 * x1_13;
      m7_13_q <= p12_q * Kb;

      s14_q   <= s13_q;
      p14_q   <= p13_q;
      m7_14_q <= m7_13_q;
      m3_14_q <= xx13_q * Ka;

      s15_q    <= s14_q;
      p15_q    <= p14_q;
      corr15_q <= sdiv_pow2(sum_15, 4);

      st16_q <= st_d;
      t16_q  <= ok15 ? s15_q.t : 32'sd0;
      p16_q  <= ok15 ? (p15_q + corr15_q) : 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
      v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0; v11_q <= 1'b0;
      v12_q <= 1'b0; v13_q <= 1'b0; v14_q <= 1'b0; v15_q <= 1'b0;
      v16_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid; v1_q <= v0_q; v2_q <= v1_q; v3_q <= dv1;
      v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
      v8_q <= v7_q; v9_q <= v8_q; v10_q <= v9_q; v11_q <= v10_q;
      v12_q <= dv2; v13_q <= v12_q; v14_q <= v13_q; v15_q <= v14_q;
      v16_q <= v15_q;
    end
  end

  assign m_axis_tvalid = v16_q;
  assign m_axis_tuser  = st16_q;
  assign m_axis_tdata  = {p16_q, t16_q};

endmodule

// ===== rtl/core/bmpc_div.sv =====
// bmpc_div: pipelined unsigned restoring divider, one quotient bit per stage
// depends on bmpc_pkg for the operand width
module bmpc_div
  import bmpc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DivW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  output logic            valid_o,
  output logic [DivW-1:0] quo_o
);

  logic [DivW-1:0] rem_w [DivW+1];
  logic [DivW-1:0] n_w   [DivW+1];
  logic [DivW-1:0] d_w   [DivW+1];
  logic            v_w   [DivW+1];

  assign rem_w[0] = '0;
  assign n_w[0]   = num_i;
  assign d_w[0]   = den_i;
  assign v_w[0]   = valid_i;

  for (genvar s = 0; s < DivW; s++) begin : g_stage
    logic [DivW:0]   r;
    logic            ge;
    logic [DivW-1:0] rem_d, rem_q, n_q, d_q;
    logic            v_q;

    assign r     = {rem_w[s], n_w[s][DivW-1]};
    assign ge    = (r >= {1'b0, d_w[s]});
    assign rem_d = ge ? DivW'(r - {1'b0, d_w[s]}) : r[DivW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        n_q   <= {n_w[s][DivW-2:0], ge};
        d_q   <= d_w[s];
      end
    end

    assign rem_w[s+1] = rem_q;
    assign n_w[s+1]   = n_q;
    assign d_w[s+1]   = d_q;
    assign v_w[s+1]   = v_q;
  end

  assign valid_o = v_w[DivW];
  assign quo_o   = n_w[DivW];

endmodule
